FILE: src/fit_policy_block_allocator_top_defines.svh
// Assertion macros for the allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FPBA_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) \
   prop) else $error("fpba assertion failed");
`define FPBA_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clock) \
   disable iff (reset) (ante) |=> (cons)) else $error("fpba assertion failed");
`else
`define FPBA_ASSERT(lbl, prop)
`define FPBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/fpba_pkg.sv
package fpba_pkg;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   localparam logic CSR_FIT_MODE    = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam int SIZE_W = 16;
   localparam int BIDX_W = 6;
   localparam int BCNT_W = 7;
   localparam int RNUM_W = 16;
   localparam int DATA_W = 24;

   typedef struct packed {
      logic       found;
      logic [1:0] mode;
   } cmp_ctrl_type;

   typedef struct packed {
      logic take;
      logic stop;
   } cmp_res_type;

endpackage

FILE: src/fpba_mem.sv
module fpba_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [fpba_pkg::SIZE_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic [fpba_pkg::SIZE_W-1:0] rdata
);
   import fpba_pkg::*;

   logic [SIZE_W-1:0] mem_ff [DEPTH];
   logic [SIZE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/fpba_cmp.sv
module fpba_cmp (
   input  fpba_pkg::cmp_ctrl_type      ctrl,
   input  logic [fpba_pkg::SIZE_W-1:0] cand,
   input  logic [fpba_pkg::SIZE_W-1:0] req,
   input  logic [fpba_pkg::SIZE_W-1:0] best,
   output fpba_pkg::cmp_res_type       res
);
   import fpba_pkg::*;

   logic fits;
   logic better;
   logic first;

   always_comb begin
      fits   = (cand >= req);
      better = 1'b0;
      first  = 1'b0;
      unique case (ctrl.mode)
         MODE_BEST:  better = (cand < best);
         MODE_WORST: better = (cand > best);
         default:    first  = 1'b1;
      endcase
      res.take = fits && (!ctrl.found || better);
      res.stop = res.take && first;
   end

endmodule

FILE: src/fit_policy_block_allocator_top.sv
// Load word: no response word. Allocate word: accept, then a scan (one read per block,
// a wait on the registered read, and a step to close the scan), then write-back.
// The response word is valid from the cycle after write-back. First fit ends the scan early.
// Not ready while a word is at work; write-back waits while an older response word is held.
// Synchronous active-high reset clears control state and counter; load the table before use.
`include "fit_policy_block_allocator_top_defines.svh"

module fit_policy_block_allocator_top #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // block_index [5:0], size_value [21:6], zero pad [23:22]
   input  logic [fpba_pkg::DATA_W-1:0] req_tdata,
   // action [0]
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // chosen_block [5:0], request_number [21:6], zero pad [23:22]
   output logic [fpba_pkg::DATA_W-1:0] rsp_tdata,
   // allocated [0]
   output logic                        rsp_tuser,
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [fpba_pkg::BCNT_W-1:0] csr_wdata
);
   import fpba_pkg::*;

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WB} state_type;

   state_type         state_ff, state_in;
   logic [1:0]        fit_mode_ff, fit_mode_in;
   logic [BCNT_W-1:0] block_count_ff, block_count_in;
   logic [RNUM_W-1:0] req_cnt_ff, req_cnt_in;
   logic [SIZE_W-1:0] req_size_ff, req_size_in;
   logic [CW-1:0]     lim_ff, lim_in;
   logic [CW-1:0]     j_ff, j_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     ridx_ff, ridx_in;
   logic              found_ff, found_in;
   logic [SIZE_W-1:0] best_ff, best_in;
   logic [AW-1:0]     pick_ff, pick_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_alloc_ff, rsp_alloc_in;
   logic [BIDX_W-1:0] rsp_blk_ff, rsp_blk_in;
   logic [RNUM_W-1:0] rsp_num_ff, rsp_num_in;

   logic              req_action;
   logic [BIDX_W-1:0] req_block_index;
   logic [SIZE_W-1:0] req_size_value;
   logic [31:0]       idx_ext;
   logic [31:0]       bc_ext;
   logic [31:0]       pick_ext;
   logic              load_ok;
   logic [CW-1:0]     lim_calc;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [SIZE_W-1:0] mem_wdata;
   logic [SIZE_W-1:0] mem_rdata;

   cmp_ctrl_type      cmp_ctrl;
   cmp_res_type       cmp_res;

   assign req_action      = req_tuser;
   assign req_block_index = req_tdata[BIDX_W-1:0];
   assign req_size_value  = req_tdata[BIDX_W+SIZE_W-1:BIDX_W];

   assign idx_ext  = 32'(req_block_index);
   assign bc_ext   = 32'(block_count_ff);
   assign pick_ext = 32'(pick_ff);
   assign load_ok  = (idx_ext < NUM_BLOCKS);
   assign lim_calc = (bc_ext > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : bc_ext[CW-1:0];

   assign cmp_ctrl.found = found_ff;
   assign cmp_ctrl.mode  = fit_mode_ff;

   fpba_mem #(
      .DEPTH (NUM_BLOCKS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (j_ff[AW-1:0]),
      .rdata (mem_rdata)
   );

   fpba_cmp u_cmp (
      .ctrl (cmp_ctrl),
      .cand (mem_rdata),
      .req  (req_size_ff),
      .best (best_ff),
      .res  (cmp_res)
   );

   always_comb begin
      state_in       = state_ff;
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      req_cnt_in     = req_cnt_ff;
      req_size_in    = req_size_ff;
      lim_in         = lim_ff;
      j_in           = j_ff;
      pend_in        = pend_ff;
      ridx_in        = ridx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      pick_in        = pick_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_blk_in     = rsp_blk_ff;
      rsp_num_in     = rsp_num_ff;
      mem_we         = 1'b0;
      mem_waddr      = pick_ff;
      mem_wdata      = best_ff - req_size_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_FIT_MODE:    fit_mode_in    = csr_wdata[1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_wdata;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_action == ACT_LOAD) begin
                  mem_we     = load_ok;
                  mem_waddr  = idx_ext[AW-1:0];
                  mem_wdata  = req_size_value;
                  req_cnt_in = '0;
               end else begin
                  req_cnt_in  = req_cnt_ff + RNUM_W'(1);
                  req_size_in = req_size_value;
                  lim_in      = lim_calc;
                  j_in        = '0;
                  pend_in     = 1'b0;
                  found_in    = 1'b0;
                  state_in    = (lim_calc == '0) ? ST_WB : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (j_ff < lim_ff) begin
               pend_in = 1'b1;
               ridx_in = j_ff[AW-1:0];
               j_in    = j_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && cmp_res.take) begin
               found_in = 1'b1;
               best_in  = mem_rdata;
               pick_in  = ridx_ff;
            end
            if ((pend_ff && cmp_res.stop) || (!pend_ff && (j_ff >= lim_ff))) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (!rsp_valid_ff || rsp_tready) begin
               mem_we       = found_ff;
               rsp_valid_in = 1'b1;
               rsp_alloc_in = found_ff;
               rsp_blk_in   = found_ff ? pick_ext[BIDX_W-1:0] : '0;
               rsp_num_in   = req_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= MODE_FIRST;
         block_count_ff <= BCNT_W'(64);
         req_cnt_ff     <= '0;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         req_cnt_ff     <= req_cnt_in;
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_size_ff  <= req_size_in;
      lim_ff       <= lim_in;
      j_ff         <= j_in;
      ridx_ff      <= ridx_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      rsp_alloc_ff <= rsp_alloc_in;
      rsp_blk_ff   <= rsp_blk_in;
      rsp_num_ff   <= rsp_num_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_alloc_ff;
   assign rsp_tdata  = {{(DATA_W - BIDX_W - RNUM_W){1'b0}}, rsp_num_ff, rsp_blk_ff};

   `FPBA_ASSERT(a_noalloc_blk_zero, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[5:0] == 6'd0))
   `FPBA_ASSERT(a_we_state, mem_we |-> (state_ff == ST_IDLE || state_ff == ST_WB))
   `FPBA_ASSERT(a_pend_limit, (state_ff == ST_SCAN && pend_ff) |-> (ridx_ff < lim_ff))
   `FPBA_ASSERT_NEXT(a_wb_rsp, state_ff == ST_WB && !rsp_valid_ff, rsp_valid_ff)

endmodule

FILE: tb/tb_fit_policy_block_allocator_top.sv
module tb_fit_policy_block_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fpba_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int SETTLE_CYCLES = 80;
   localparam int SEGMENT_WORDS = 112;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic        allocated;
      logic [5:0]  block;
      logic [15:0] seq;
   } grant_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we = 1'b0;
   logic              csr_addr = 1'b0;
   logic [BCNT_W-1:0] csr_wdata = '0;

   logic [15:0] free_left [TABLE_DEPTH];
   logic [15:0] req_seq = '0;
   logic [1:0]  cur_mode = MODE_FIRST;
   logic [6:0]  cur_count = 7'd64;
   grant_type   grant_q [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   fit_policy_block_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t: mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
      end
   endtask

   function automatic void predict_grant(input logic act, input logic [5:0] idx,
                                         input logic [15:0] sz);
      grant_type g;
      int        lim;
      int        pick;
      bit        found;
      if (act == ACT_LOAD) begin
         free_left[idx] = sz;
         req_seq = '0;
         return;
      end
      lim = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
      found = 1'b0;
      pick = 0;
      for (int j = 0; j < lim; j++) begin
         if (free_left[j] >= sz) begin
            if (!found) begin
               found = 1'b1;
               pick = j;
               if (cur_mode != MODE_BEST && cur_mode != MODE_WORST) break;
            end else if (cur_mode == MODE_BEST && free_left[j] < free_left[pick]) begin
               pick = j;
            end else if (cur_mode == MODE_WORST && free_left[j] > free_left[pick]) begin
               pick = j;
            end
         end
      end
      req_seq = req_seq + 16'd1;
      g.seq = req_seq;
      if (found) begin
         free_left[pick] = free_left[pick] - sz;
         g.allocated = 1'b1;
         g.block = pick[5:0];
      end else begin
         g.allocated = 1'b0;
         g.block = '0;
      end
      grant_q.push_back(g);
   endfunction

   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            report_mismatch("unexpected result word", int'(rsp_tdata), -1);
         end else begin
            g = grant_q.pop_front();
            if (rsp_tuser !== g.allocated)
               report_mismatch("allocated", int'(rsp_tuser), int'(g.allocated));
            if (rsp_tdata[5:0] !== g.block)
               report_mismatch("chosen_block", int'(rsp_tdata[5:0]), int'(g.block));
            if (rsp_tdata[21:6] !== g.seq)
               report_mismatch("request_number", int'(rsp_tdata[21:6]), int'(g.seq));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_word(input logic act, input logic [5:0] idx, input logic [15:0] sz);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {2'b00, sz, idx};
      do @(posedge clock); while (!req_tready);
      predict_grant(act, idx, sz);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (grant_q.size() != 0);
   endtask

   task automatic write_reg(input logic addr, input logic [6:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_FIT_MODE) cur_mode = value[1:0];
      else cur_count = value;
   endtask

   function automatic logic [15:0] rand_block_size();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'h0000;
      if (r < 10) return 16'hFFFF;
      if (r < 30) return 16'd256 << $urandom_range(2);
      if (r < 45) return 16'($urandom_range(16'hFFFF));
      return 16'($urandom_range(4095));
   endfunction

   task automatic send_random_word();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         send_word(ACT_LOAD, 6'($urandom_range(63)), rand_block_size());
      end else if (r < 23) begin
         send_word(ACT_ALLOC, 6'($urandom_range(63)), 16'h0000);
      end else if (r < 28) begin
         send_word(ACT_ALLOC, 6'($urandom_range(63)), 16'hFFFF);
      end else if (r < 35) begin
         send_word(ACT_ALLOC, 6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)));
      end else begin
         send_word(ACT_ALLOC, 6'($urandom_range(63)), 16'($urandom_range(511)));
      end
   endtask

   task automatic test_fill_table();
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) send_word(ACT_LOAD, 6'(i), rand_block_size());
   endtask

   task automatic test_fit_corners();
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(CSR_BLOCK_COUNT, 7'd4);
      send_word(ACT_LOAD, 6'd0, 16'hFFFF);
      send_word(ACT_LOAD, 6'd1, 16'h0000);
      send_word(ACT_LOAD, 6'd2, 16'd300);
      send_word(ACT_LOAD, 6'd3, 16'd200);
      send_word(ACT_LOAD, 6'd63, 16'hFFFF);
      send_word(ACT_ALLOC, 6'd63, 16'h0000);
      send_word(ACT_ALLOC, 6'd0, 16'hFFFF);
      send_word(ACT_ALLOC, 6'd0, 16'hFFFF);
      write_reg(CSR_FIT_MODE, 7'(MODE_BEST));
      send_word(ACT_ALLOC, 6'd0, 16'd150);
      send_word(ACT_ALLOC, 6'd0, 16'd0);
      write_reg(CSR_FIT_MODE, 7'(MODE_WORST));
      send_word(ACT_LOAD, 6'd1, 16'd500);
      send_word(ACT_LOAD, 6'd3, 16'd500);
      send_word(ACT_ALLOC, 6'd0, 16'd10);
      send_word(ACT_ALLOC, 6'd0, 16'd10);
      write_reg(CSR_FIT_MODE, 7'(MODE_SPARE));
      send_word(ACT_ALLOC, 6'd0, 16'd295);
      write_reg(CSR_BLOCK_COUNT, 7'd0);
      send_word(ACT_ALLOC, 6'd0, 16'd0);
      write_reg(CSR_BLOCK_COUNT, 7'd127);
      write_reg(CSR_FIT_MODE, 7'(MODE_WORST));
      send_word(ACT_ALLOC, 6'd0, 16'hFFFF);
      write_reg(CSR_BLOCK_COUNT, 7'd64);
      send_word(ACT_ALLOC, 6'd0, 16'd1);
      write_reg(CSR_BLOCK_COUNT, 7'd1);
      write_reg(CSR_FIT_MODE, 7'(MODE_BEST));
      send_word(ACT_ALLOC, 6'd0, 16'd0);
   endtask

   task automatic test_random_mix(input int send_pct, input int hold_pct);
      logic [1:0] mode_list [4];
      logic [6:0] cnt;
      int         r;
      mode_list = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE};
      send_idle_pct = send_pct;
      stall_pct = hold_pct;
      for (int seg = 0; seg < 4; seg++) begin
         r = $urandom_range(9);
         unique case (r)
            0: cnt = 7'd0;
            1: cnt = 7'd1;
            2: cnt = 7'd64;
            3: cnt = 7'($urandom_range(127, 65));
            4, 5, 6: cnt = 7'($urandom_range(64, 1));
            default: cnt = 7'($urandom_range(16, 2));
         endcase
         write_reg(CSR_FIT_MODE, 7'(mode_list[seg]));
         write_reg(CSR_BLOCK_COUNT, cnt);
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            if (n == SEGMENT_WORDS / 2) wait_results_drained();
            send_random_word();
         end
      end
   endtask

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_fill_table();
      test_fit_corners();
      test_random_mix(0, 0);
      test_random_mix(65, 0);
      test_random_mix(0, 65);
      test_random_mix(25, 25);
      req_tvalid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (grant_q.size() != 0 && guard < 20000);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (grant_q.size() != 0) report_mismatch("results never returned", 0, grant_q.size());
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/fpba_pkg.sv
src/fpba_mem.sv
src/fpba_cmp.sv
src/fit_policy_block_allocator_top.sv
tb/tb_fit_policy_block_allocator_top.sv
